// ----- src/mbet_pkg.sv -----
// Shared package for the escape-time classifier: request/result structs,
// class codes, multiplier control struct and saturating add helpers.
// No dependencies.
`default_nettype none

package mbet_pkg;

    localparam int FRAC_BITS_DEF  = 55;
    localparam int COUNT_BITS_DEF = 17;

    localparam logic [1:0] CLASS_ESCAPED = 2'd0;
    localparam logic [1:0] CLASS_BULB    = 2'd1;
    localparam logic [1:0] CLASS_BOUNDED = 2'd2;

    localparam int REG_LIMIT  = 0;
    localparam int REG_THRESH = 1;

    typedef struct packed {
        logic signed [63:0] point_real;
        logic signed [63:0] point_imag;
    } point_t;

    typedef struct packed {
        logic [1:0]  point_class;
        logic [16:0] escape_count;
        logic [62:0] final_magnitude_sq;
    } result_t;

    typedef struct packed {
        logic start;
        logic dbl;
    } mul_req_t;

    // Signed 64-bit add, clamped to the signed range.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63])
        begin
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

    // Sum of two 63-bit magnitudes, clamped to 2^63-1.
    function automatic logic [62:0] usat_add(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? {63{1'b1}} : s[62:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/mbet_mul.sv -----
// Iterative 64x64 fixed-point multiplier on one 32x32 multiplier:
// four partial products, then shift and saturate. Uses mbet_pkg.
`default_nettype none

module mbet_mul #(
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mbet_pkg::mul_req_t  req,
    input  logic signed [63:0]  a,
    input  logic signed [63:0]  b,
    output logic                done,
    output logic signed [63:0]  product
);
    import mbet_pkg::*;

    logic [63:0]        am_reg, bm_reg;
    logic               neg_reg, dbl_reg;
    logic [127:0]       acc_reg;
    logic [2:0]         step_reg;
    logic               done_reg;
    logic signed [63:0] prod_reg;

    logic [31:0]  ma, mb;
    logic [63:0]  pp;
    logic [127:0] pp_ext;
    logic [127:0] shifted;
    logic [63:0]  r;
    logic         fits;
    logic signed [63:0] prod_next;

    always_comb
    begin
        ma     = '0;
        mb     = '0;
        pp     = '0;
        pp_ext = '0;
        case (step_reg)
            3'd1:
            begin
                ma = am_reg[31:0];
                mb = bm_reg[31:0];
            end
            3'd2:
            begin
                ma = am_reg[31:0];
                mb = bm_reg[63:32];
            end
            3'd3:
            begin
                ma = am_reg[63:32];
                mb = bm_reg[31:0];
            end
            3'd4:
            begin
                ma = am_reg[63:32];
                mb = bm_reg[63:32];
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        pp = {32'd0, ma} * {32'd0, mb};
        case (step_reg)
            3'd1:    pp_ext = {64'd0, pp};
            3'd2:    pp_ext = {32'd0, pp, 32'd0};
            3'd3:    pp_ext = {32'd0, pp, 32'd0};
            3'd4:    pp_ext = {pp, 64'd0};
            default: pp_ext = '0;
        endcase
    end

    // Shift out the fraction and clamp to the signed range.
    always_comb
    begin
        shifted = dbl_reg ? (acc_reg >> (FRAC_BITS - 1)) : (acc_reg >> FRAC_BITS);
        fits    = (shifted[127:64] == 64'd0);
        r       = shifted[63:0];
        if (neg_reg)
        begin
            if (!fits || (r > {1'b1, 63'd0}))
            begin
                r = {1'b1, 63'd0};
            end
            prod_next = -$signed(r);
        end
        else
        begin
            if (!fits || r[63])
            begin
                r = {1'b0, {63{1'b1}}};
            end
            prod_next = $signed(r);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                step_reg <= 3'd1;
            end
            else if (step_reg == 3'd5)
            begin
                step_reg <= 3'd0;
                done_reg <= 1'b1;
            end
            else if (step_reg != 3'd0)
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            am_reg  <= a[63] ? (~a + 64'd1) : a;
            bm_reg  <= b[63] ? (~b + 64'd1) : b;
            neg_reg <= a[63] ^ b[63];
            dbl_reg <= req.dbl;
            acc_reg <= '0;
        end
        else if (step_reg != 3'd0 && step_reg != 3'd5)
        begin
            acc_reg <= acc_reg + pp_ext;
        end
        if (step_reg == 3'd5)
        begin
            prod_reg <= prod_next;
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

// ----- src/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time classifier, top level. Depends on mbet_pkg, mbet_mul.
// Products: every 64x64 product runs on the shared 32x32 multiplier
//   as four partial products, one shift/clamp and one handoff.
//   Bulb hits: 3 to FRAC_BITS+4 products.
//   Iterating points: three products per z step. One point is worked on
//   at a time; the next request is taken the cycle after the result is
//   accepted.
// Reset: registers return to limit 256 and threshold 4.0; block goes idle.
`default_nettype none

module mandelbrot_escape_time #(
    parameter int FRAC_BITS  = mbet_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = mbet_pkg::COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    input  logic              point_valid,
    output logic              point_stall,
    input  mbet_pkg::point_t  point,
    output logic              result_valid,
    input  logic              result_stall,
    output mbet_pkg::result_t result
);
    import mbet_pkg::*;

    localparam logic signed [63:0] ONE       = 64'(1) << FRAC_BITS;
    localparam logic signed [63:0] QUARTER   = 64'(1) << (FRAC_BITS - 2);
    localparam logic [62:0]        SIXTEENTH = 63'(1) << (FRAC_BITS - 4);
    localparam logic [62:0]        THRESH_RST = 63'(4) << FRAC_BITS;
    localparam logic [32:0]        CMAX      = (33'd1 << COUNT_BITS) - 33'd1;
    localparam int                 BIT_W     = $clog2(FRAC_BITS);
    localparam logic [3:0]         ADDR_LIMIT  = 4'(8 * REG_LIMIT);
    localparam logic [3:0]         ADDR_THRESH = 4'(8 * REG_THRESH);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_WAIT   = 16'h0002,
        S_B_Y2   = 16'h0004,
        S_B_Q    = 16'h0008,
        S_B_SQRT = 16'h0010,
        S_B_CARD = 16'h0020,
        S_B_BULB = 16'h0040,
        S_OUTER  = 16'h0080,
        S_CHECK  = 16'h0100,
        S_R2     = 16'h0200,
        S_I2     = 16'h0400,
        S_ZI     = 16'h0800,
        S_E_ZI   = 16'h1000,
        S_E_R2   = 16'h2000,
        S_E_I2   = 16'h4000,
        S_OUT    = 16'h8000
    } state_t;

    // Configuration registers
    logic [15:0] limit_reg;
    logic [62:0] thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= 16'd256;
            thresh_reg <= THRESH_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_LIMIT)
            begin
                limit_reg <= pwdata[15:0];
            end
            else if (paddr == ADDR_THRESH)
            begin
                thresh_reg <= pwdata[62:0];
            end
        end
    end

    always_comb
    begin
        if (paddr == ADDR_LIMIT)
        begin
            prdata = {48'd0, limit_reg};
        end
        else if (paddr == ADDR_THRESH)
        begin
            prdata = {1'b0, thresh_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign pready = 1'b1;

    // Sequencer state and datapath registers
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic signed [63:0] x_reg, x_next, y_reg, y_next;
    logic signed [63:0] zr_reg, zr_next, zi_reg, zi_next;
    logic signed [63:0] sr_reg, sr_next, si_reg, si_next;
    logic signed [63:0] p_reg, p_next, c_reg, c_next;
    logic [62:0] y2_reg, y2_next, q_reg, q_next;
    logic [62:0] r2_reg, r2_next, i2_reg, i2_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [15:0] n_reg, n_next, total_reg, total_next;
    logic        k_reg, k_next;
    result_t     res_reg, res_next;

    // Shared multiplier hookup
    mul_req_t           mreq;
    logic signed [63:0] mul_a, mul_b, mul_p;
    logic               mul_done;

    mbet_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    logic signed [63:0] d_val, c_val, p_new, rhs, zr_new, zi_new;
    logic [62:0]        q_sum;
    logic [16:0]        tot2, cnt;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        sr_next    = sr_reg;
        si_next    = si_reg;
        p_next     = p_reg;
        c_next     = c_reg;
        y2_next    = y2_reg;
        q_next     = q_reg;
        r2_next    = r2_reg;
        i2_next    = i2_reg;
        bit_next   = bit_reg;
        n_next     = n_reg;
        total_next = total_reg;
        k_next     = k_reg;
        res_next   = res_reg;
        mreq       = '0;
        mul_a      = '0;
        mul_b      = '0;

        d_val  = '0;
        c_val  = '0;
        p_new  = '0;
        rhs    = '0;
        q_sum  = '0;
        tot2   = '0;
        cnt    = '0;
        zi_new = sat_add(mul_p, y_reg);
        zr_new = sat_add($signed({1'b0, r2_reg}) - $signed({1'b0, i2_reg}), x_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    // Take the request and square the imaginary part first.
                    x_next     = point.point_real;
                    y_next     = point.point_imag;
                    mul_a      = point.point_imag;
                    mul_b      = point.point_imag;
                    mreq.start = 1'b1;
                    ret_next   = S_B_Y2;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = ret_reg;
                end
            end
            S_B_Y2:
            begin
                y2_next    = mul_p[62:0];
                d_val      = sat_add(x_reg, -QUARTER);
                mul_a      = d_val;
                mul_b      = d_val;
                mreq.start = 1'b1;
                ret_next   = S_B_Q;
                state_next = S_WAIT;
            end
            S_B_Q:
            begin
                q_sum  = usat_add(mul_p[62:0], y2_reg);
                q_next = q_sum;
                if ({1'b0, q_sum} < ONE)
                begin
                    // Start the bit-by-bit square root from the top fraction bit.
                    c_val      = QUARTER <<< 1;
                    p_next     = '0;
                    c_next     = c_val;
                    bit_next   = BIT_W'(FRAC_BITS - 1);
                    mul_a      = c_val;
                    mul_b      = c_val;
                    ret_next   = S_B_SQRT;
                end
                else
                begin
                    d_val    = sat_add(x_reg, ONE);
                    mul_a    = d_val;
                    mul_b    = d_val;
                    ret_next = S_B_BULB;
                end
                mreq.start = 1'b1;
                state_next = S_WAIT;
            end
            S_B_SQRT:
            begin
                p_new  = (mul_p[62:0] <= q_reg) ? c_reg : p_reg;
                p_next = p_new;
                if (bit_reg == '0)
                begin
                    mul_a    = p_new;
                    mul_b    = p_new;
                    ret_next = S_B_CARD;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                    c_val    = p_new | (64'(1) << (bit_reg - BIT_W'(1)));
                    c_next   = c_val;
                    mul_a    = c_val;
                    mul_b    = c_val;
                    ret_next = S_B_SQRT;
                end
                mreq.start = 1'b1;
                state_next = S_WAIT;
            end
            S_B_CARD:
            begin
                rhs = p_reg - (mul_p <<< 1) + QUARTER;
                if (x_reg < rhs)
                begin
                    res_next   = '{CLASS_BULB, 17'd0, 63'd0};
                    state_next = S_OUT;
                end
                else
                begin
                    d_val      = sat_add(x_reg, ONE);
                    mul_a      = d_val;
                    mul_b      = d_val;
                    mreq.start = 1'b1;
                    ret_next   = S_B_BULB;
                    state_next = S_WAIT;
                end
            end
            S_B_BULB:
            begin
                if (usat_add(mul_p[62:0], y2_reg) < SIXTEENTH)
                begin
                    res_next   = '{CLASS_BULB, 17'd0, 63'd0};
                    state_next = S_OUT;
                end
                else
                begin
                    zr_next    = x_reg;
                    zi_next    = y_reg;
                    n_next     = '0;
                    total_next = 16'd8;
                    state_next = S_OUTER;
                end
            end
            S_OUTER:
            begin
                // Save z for the cycle check and double the window, capped at the limit.
                sr_next = zr_reg;
                si_next = zi_reg;
                tot2    = {total_reg, 1'b0};
                if (tot2 > {1'b0, limit_reg})
                begin
                    total_next = limit_reg;
                end
                else
                begin
                    total_next = tot2[15:0];
                end
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (n_reg < total_reg)
                begin
                    mul_a      = zr_reg;
                    mul_b      = zr_reg;
                    mreq.start = 1'b1;
                    ret_next   = S_R2;
                    state_next = S_WAIT;
                end
                else if (total_reg != limit_reg)
                begin
                    state_next = S_OUTER;
                end
                else
                begin
                    res_next   = '{CLASS_BOUNDED, 17'd0, 63'd0};
                    state_next = S_OUT;
                end
            end
            S_R2:
            begin
                r2_next    = mul_p[62:0];
                mul_a      = zi_reg;
                mul_b      = zi_reg;
                mreq.start = 1'b1;
                ret_next   = S_I2;
                state_next = S_WAIT;
            end
            S_I2:
            begin
                i2_next    = mul_p[62:0];
                mul_a      = zr_reg;
                mul_b      = zi_reg;
                mreq.start = 1'b1;
                mreq.dbl   = 1'b1;
                if (usat_add(r2_reg, mul_p[62:0]) > thresh_reg)
                begin
                    k_next   = 1'b0;
                    ret_next = S_E_ZI;
                end
                else
                begin
                    ret_next = S_ZI;
                end
                state_next = S_WAIT;
            end
            S_ZI:
            begin
                zi_next = zi_new;
                zr_next = zr_new;
                if (zr_new == sr_reg && zi_new == si_reg)
                begin
                    res_next   = '{CLASS_BOUNDED, 17'd0, 63'd0};
                    state_next = S_OUT;
                end
                else
                begin
                    n_next     = n_reg + 16'd1;
                    state_next = S_CHECK;
                end
            end
            S_E_ZI:
            begin
                zi_next    = zi_new;
                zr_next    = zr_new;
                mul_a      = zr_new;
                mul_b      = zr_new;
                mreq.start = 1'b1;
                ret_next   = S_E_R2;
                state_next = S_WAIT;
            end
            S_E_R2:
            begin
                r2_next    = mul_p[62:0];
                mul_a      = zi_reg;
                mul_b      = zi_reg;
                mreq.start = 1'b1;
                ret_next   = S_E_I2;
                state_next = S_WAIT;
            end
            S_E_I2:
            begin
                i2_next = mul_p[62:0];
                if (!k_reg)
                begin
                    k_next     = 1'b1;
                    mul_a      = zr_reg;
                    mul_b      = zi_reg;
                    mreq.start = 1'b1;
                    mreq.dbl   = 1'b1;
                    ret_next   = S_E_ZI;
                    state_next = S_WAIT;
                end
                else
                begin
                    cnt = {1'b0, n_reg} + 17'd3;
                    if ({16'd0, cnt} > CMAX)
                    begin
                        cnt = CMAX[16:0];
                    end
                    res_next   = '{CLASS_ESCAPED, cnt, usat_add(r2_reg, mul_p[62:0])};
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        sr_reg    <= sr_next;
        si_reg    <= si_next;
        p_reg     <= p_next;
        c_reg     <= c_next;
        y2_reg    <= y2_next;
        q_reg     <= q_next;
        r2_reg    <= r2_next;
        i2_reg    <= i2_next;
        bit_reg   <= bit_next;
        n_reg     <= n_next;
        total_reg <= total_next;
        k_reg     <= k_next;
        res_reg   <= res_next;
    end

    // Hold off new requests until the current result is taken.
    assign point_stall  = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT);
    assign result       = res_reg;

endmodule

`default_nettype wire

// ----- tb/mandelbrot_escape_time_test.sv -----
// Self-checking regression for the escape-time classifier mandelbrot_escape_time.
// Depends on mbet_pkg (request/result structs, class and register codes) and the RTL.
`timescale 1ns / 100ps

module mandelbrot_escape_time_test;
    import mbet_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int CNT_W = COUNT_BITS_DEF;
    localparam logic [62:0] MAG_MAX = {63{1'b1}};
    localparam logic signed [63:0] S_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S_MIN = {1'b1, 63'd0};
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC;
    localparam logic signed [63:0] QUARTER = ONE >>> 2;
    localparam logic [62:0] SIXTEENTH = 63'd1 << (FRAC - 4);
    localparam logic [62:0] FOUR = 63'd4 << FRAC;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    logic point_valid = 1'b0;
    logic point_stall;
    point_t point = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;

    // Mirror of the block's registers, kept in step with every APB write.
    logic [15:0] cur_limit = 16'd256;
    logic [62:0] cur_thresh = FOUR;

    result_t pending_q[$];
    bit steady = 1'b0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_mismatch = 0;
    int unsigned n_class[3] = '{0, 0, 0};

    mandelbrot_escape_time dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .point_valid(point_valid), .point_stall(point_stall), .point(point),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    always #1 clk = ~clk;

    // ---------------- fixed-point arithmetic of the classifier ----------------

    function automatic logic [63:0] magnitude(input logic signed [63:0] a);
        return a[63] ? (~a + 64'd1) : a;
    endfunction

    // Square, truncated, clamped to 2^63-1.
    function automatic logic [62:0] fx_square(input logic signed [63:0] a);
        logic [127:0] p;
        p = {64'd0, magnitude(a)};
        p = (p * p) >> FRAC;
        return (p > MAG_MAX) ? MAG_MAX : p[62:0];
    endfunction

    // Signed product of magnitudes shifted by sh, clamped to the signed range.
    function automatic logic signed [63:0] fx_product(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      input int sh);
        logic [127:0] p;
        logic [127:0] mb;
        p = {64'd0, magnitude(a)};
        mb = {64'd0, magnitude(b)};
        p = (p * mb) >> sh;
        if (a[63] != b[63])
        begin
            if (p > {64'd0, 1'b1, 63'd0})
                return S_MIN;
            return -p[63:0];
        end
        return (p > {64'd0, S_MAX}) ? S_MAX : p[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_sum(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S_MIN : S_MAX;
        return s[63:0];
    endfunction

    function automatic logic [62:0] mag_sum(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? MAG_MAX : s[62:0];
    endfunction

    // Main cardioid (square-root form) or period-2 bulb membership.
    function automatic bit in_bulb(input logic signed [63:0] x, input logic signed [63:0] y);
        logic [62:0] y2;
        logic [62:0] q;
        logic signed [63:0] root;
        logic signed [63:0] trial;
        logic signed [63:0] rhs;
        y2 = fx_square(y);
        q = mag_sum(fx_square(clamp_sum(x, -QUARTER)), y2);
        if (q < ONE[62:0])
        begin
            root = '0;
            for (int b = FRAC - 1; b >= 0; b--)
            begin
                trial = root | (64'sd1 <<< b);
                if (fx_square(trial) <= q)
                    root = trial;
            end
            rhs = root - 2 * $signed({1'b0, fx_square(root)}) + QUARTER;
            if (x < rhs)
                return 1'b1;
        end
        return mag_sum(fx_square(clamp_sum(x, ONE)), y2) < SIXTEENTH;
    endfunction

    // Expected classification of one point under the current register values.
    function automatic result_t classify_point(input logic signed [63:0] cr,
                                               input logic signed [63:0] ci);
        result_t r;
        int unsigned n;
        int unsigned span;
        int unsigned cnt;
        logic signed [63:0] zr;
        logic signed [63:0] zi;
        logic signed [63:0] sr;
        logic signed [63:0] si;
        logic [62:0] r2;
        logic [62:0] i2;
        r = '{point_class: CLASS_BULB, escape_count: '0, final_magnitude_sq: '0};
        if (in_bulb(cr, ci))
            return r;
        r.point_class = CLASS_BOUNDED;
        n = 0;
        span = 8;
        zr = cr;
        zi = ci;
        do
        begin
            sr = zr;
            si = zi;
            span = span + span;
            if (span > cur_limit)
                span = {16'd0, cur_limit};
            while (n < span)
            begin
                r2 = fx_square(zr);
                i2 = fx_square(zi);
                if (mag_sum(r2, i2) > cur_thresh)
                begin
                    // two extra steps past escape
                    for (int k = 0; k < 2; k++)
                    begin
                        zi = clamp_sum(fx_product(zr, zi, FRAC - 1), ci);
                        zr = clamp_sum($signed({1'b0, r2}) - $signed({1'b0, i2}), cr);
                        r2 = fx_square(zr);
                        i2 = fx_square(zi);
                    end
                    cnt = n + 3;
                    if (cnt > (1 << CNT_W) - 1)
                        cnt = (1 << CNT_W) - 1;
                    r.point_class = CLASS_ESCAPED;
                    r.escape_count = cnt[16:0];
                    r.final_magnitude_sq = mag_sum(r2, i2);
                    return r;
                end
                zi = clamp_sum(fx_product(zr, zi, FRAC - 1), ci);
                zr = clamp_sum($signed({1'b0, r2}) - $signed({1'b0, i2}), cr);
                if (zr == sr && zi == si)
                    return r;
                n++;
            end
        end
        while (span != cur_limit);
        return r;
    endfunction

    // ---------------- drivers ----------------

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    // Send one request; valid stays high after acceptance until the next gap or wait_idle.
    task automatic send_point(input logic signed [63:0] re, input logic signed [63:0] im);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pending_q.push_back(classify_point(re, im));
        point_valid <= 1'b1;
        point <= '{point_real: re, point_imag: im};
        n_sent++;
        do @(posedge clk); while (point_stall);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic wait_idle();
        point_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(input int idx, input logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(8 * idx);
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Reprogram both registers with the block idle.
    task automatic set_regs(input logic [15:0] lim, input logic [62:0] thr);
        wait_idle();
        apb_write(REG_LIMIT, {48'd0, lim});
        apb_write(REG_THRESH, {1'b0, thr});
        cur_limit = lim;
        cur_thresh = thr;
        @(posedge clk);
    endtask

    // ---------------- result checker ----------------

    initial
    begin : result_checker
        int unsigned gap;
        result_t want;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap != 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            n_checked++;
            if (pending_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: result with nothing pending: %p", result);
            end
            else
            begin
                want = pending_q.pop_front();
                if (result.point_class <= CLASS_BOUNDED)
                    n_class[result.point_class]++;
                if (result.point_class !== want.point_class
                    || result.escape_count !== want.escape_count
                    || result.final_magnitude_sq !== want.final_magnitude_sq)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: result %0d: class %0d/%0d count %0d/%0d mag %h/%h",
                                 n_checked, want.point_class, result.point_class,
                                 want.escape_count, result.escape_count,
                                 want.final_magnitude_sq, result.final_magnitude_sq);
                end
            end
        end
    end

    // ---------------- tests ----------------

    function automatic logic signed [63:0] quarters(input int k);
        return QUARTER * k;
    endfunction

    // Bulb hits, cusp, cycles, escapes, limit runs and saturated extremes
    // at the reset register values.
    task automatic test_directed_points();
        send_point(0, 0);
        send_point(quarters(-4), 0);
        send_point(quarters(1), 0);
        send_point(quarters(-8), 0);
        send_point(quarters(8), 0);
        send_point(quarters(-6), 0);
        send_point(0, quarters(4));
        send_point(quarters(-3), 0);
        send_point(quarters(-5), 0);
        send_point(quarters(1), quarters(2));
        send_point(S_MAX, S_MAX);
        send_point(S_MIN, S_MIN);
        send_point(S_MAX, S_MIN);
        send_point(S_MIN, 0);
        send_point(0, S_MAX);
        send_point(-64'sd1, 64'sd1);
    endtask

    // Zero and maximum limits, zero and maximum thresholds.
    task automatic test_register_extremes();
        set_regs(16'd0, FOUR);
        send_point(quarters(-6), 0);
        send_point(quarters(8), quarters(8));
        set_regs(16'hFFFF, FOUR);
        send_point(0, quarters(4));
        send_point(quarters(12), quarters(-2));
        send_point(quarters(-4), 0);
        set_regs(16'd1, 63'd0);
        send_point(quarters(-6), 64'sd1);
        send_point(0, 0);
        set_regs(16'd20, MAG_MAX);
        send_point(S_MAX, quarters(3));
        send_point(quarters(40), S_MIN);
    endtask

    function automatic logic signed [63:0] draw_span(input logic signed [63:0] lo,
                                                     input logic [63:0] width);
        return lo + $signed({$urandom, $urandom} % width);
    endfunction

    // Random points in phases of random register settings; some phases run without idling.
    task automatic test_random_sweep();
        logic [15:0] lim;
        logic [62:0] thr;
        logic signed [63:0] re;
        logic signed [63:0] im;
        for (int ph = 0; ph < 12; ph++)
        begin
            case ($urandom_range(0, 5))
                0: lim = 16'd1;
                1: lim = 16'd16;
                2: lim = 16'd17;
                3: lim = 16'd48;
                default: lim = 16'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 7))
                0: thr = 63'd0;
                1: thr = MAG_MAX;
                2: thr = 63'({$urandom, $urandom});
                3: thr = 63'({$urandom, $urandom} % (64'(FOUR) * 64'd4));
                default: thr = FOUR;
            endcase
            set_regs(lim, thr);
            steady = (ph % 4 == 3);
            repeat (96)
            begin
                case ($urandom_range(0, 9))
                    7:
                    begin
                        re = {$urandom, $urandom};
                        im = {$urandom, $urandom};
                    end
                    8:
                    begin
                        re = draw_span(-(ONE * 8), ONE * 16);
                        im = draw_span(-(ONE * 8), ONE * 16);
                    end
                    9:
                    begin
                        re = quarters($urandom_range(0, 16) - 8)
                             + $signed(64'($urandom_range(0, 3)) - 1);
                        im = ($urandom_range(0, 1) != 0)
                             ? S_MAX : quarters($urandom_range(0, 8) - 4);
                    end
                    6:
                    begin
                        // around the bulb centers and the cardioid rim
                        re = draw_span(quarters(-5), ONE * 2);
                        im = draw_span(-QUARTER, ONE / 2);
                    end
                    default:
                    begin
                        re = draw_span(-(QUARTER * 9), ONE * 3);
                        im = draw_span(-(QUARTER * 6), ONE * 3);
                    end
                endcase
                send_point(re, im);
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin : main_sequence
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_points();
        test_register_extremes();
        test_random_sweep();
        wait_idle();
        repeat (40) @(posedge clk);
        $display("Covered %0d points over limits 0..65535 and thresholds 0..max.", n_sent);
        $display("Escaped %0d, bulb %0d, bounded %0d; %0d mismatches.",
                 n_class[0], n_class[1], n_class[2], n_mismatch);
        if (n_mismatch == 0 && pending_q.size() == 0 && n_checked == n_sent)
            $display("mandelbrot_escape_time regression: pass");
        else
            $display("mandelbrot_escape_time regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #40000000;
        $display("mandelbrot_escape_time regression: fail");
        $finish;
    end

endmodule
